// ===== rtl/feedback_frame_parser_unit_assert.svh =====
// assertion macros for the feedback frame parser
// used by the top level; expects clk and rst_n in the including scope
`ifndef FEEDBACK_FRAME_PARSER_UNIT_ASSERT_SVH
`define FEEDBACK_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define FFP_ASSERT_IMPL(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("ffp assertion failed");
`define FFP_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("ffp assertion failed");
`else
`define FFP_ASSERT_IMPL(lbl, cond, expr)
`define FFP_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// ===== rtl/ffp_pkg.sv =====
// shared types and constants of the feedback frame parser
// no dependencies
`default_nettype none

package ffp_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    KIND_UNDECODED     = 4'd0,
    KIND_EMPTY         = 4'd1,
    KIND_UNKNOWN       = 4'd2,
    KIND_TILT          = 4'd3,
    KIND_VELOCITY      = 4'd4,
    KIND_WHEEL_DISPL   = 4'd5,
    KIND_FWD_YAW_DISPL = 4'd6,
    KIND_TORQUE        = 4'd7,
    KIND_STATUS        = 4'd8,
    KIND_HEARTBEAT     = 4'd9
  } msg_kind_t;

  // one completed frame, checksum not yet checked
  typedef struct packed {
    logic [12:0] sum;
    logic [7:0]  chk;
    logic        chan_b;
    logic [10:0] msg_id;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
  } frame_rec_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/ffp_front.sv =====
// front end: frame hunting, byte capture and running sum
// depends on ffp_pkg
`default_nettype none

module ffp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         rx_byte,
  output logic                    push,
  output ffp_pkg::frame_rec_t     rec
);

  localparam logic [7:0] SYNC0  = 8'hF0;
  localparam logic [7:0] SYNC1  = 8'h55;
  localparam logic [7:0] CHAN_A = 8'hAA;
  localparam logic [7:0] CHAN_B = 8'hBB;

  localparam logic [4:0] POS_SYNC0 = 5'd0;
  localparam logic [4:0] POS_SYNC1 = 5'd1;
  localparam logic [4:0] POS_CHAN  = 5'd2;
  localparam logic [4:0] POS_ID_HI = 5'd4;
  localparam logic [4:0] POS_ID_LO = 5'd5;
  localparam logic [4:0] POS_WA_HI = 5'd9;
  localparam logic [4:0] POS_WA_LO = 5'd10;
  localparam logic [4:0] POS_WB_HI = 5'd11;
  localparam logic [4:0] POS_WB_LO = 5'd12;
  localparam logic [4:0] POS_WC_HI = 5'd13;
  localparam logic [4:0] POS_WC_LO = 5'd14;
  localparam logic [4:0] POS_WD_HI = 5'd15;
  localparam logic [4:0] POS_WD_LO = 5'd16;
  localparam logic [4:0] POS_LAST  = 5'd17;

  logic [4:0]  pos_r, pos_nxt;
  logic [12:0] sum_r, sum_nxt;
  logic [12:0] sum_add;
  logic        chan_b_r;
  logic [10:0] id_r;
  logic [15:0] word_a_r, word_b_r, word_c_r, word_d_r;

  assign sum_add = sum_r + {5'd0, rx_byte};

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    push    = 1'b0;
    if (take) begin
      case (pos_r)
        POS_SYNC0: begin
          if (rx_byte == SYNC0) begin
            pos_nxt = POS_SYNC1;
            sum_nxt = {5'd0, rx_byte};
          end else begin
            pos_nxt = POS_SYNC0;
          end
        end
        POS_SYNC1: begin
          if (rx_byte == SYNC1) begin
            pos_nxt = POS_CHAN;
            sum_nxt = sum_add;
          end else begin
            pos_nxt = POS_SYNC0;
          end
        end
        POS_CHAN: begin
          if (rx_byte == CHAN_A || rx_byte == CHAN_B) begin
            pos_nxt = pos_r + 5'd1;
            sum_nxt = sum_add;
          end else begin
            pos_nxt = POS_SYNC0;
          end
        end
        POS_LAST: begin
          push    = 1'b1;
          pos_nxt = POS_SYNC0;
          sum_nxt = '0;
        end
        default: begin
          if (pos_r > POS_LAST) begin
            pos_nxt = POS_SYNC0;
          end else begin
            pos_nxt = pos_r + 5'd1;
            sum_nxt = sum_add;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_SYNC0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // only the bytes that reach the result are kept
  always_ff @(posedge clk) begin
    if (take) begin
      case (pos_r)
        POS_CHAN:  chan_b_r        <= (rx_byte == CHAN_B);
        POS_ID_HI: id_r[10:3]      <= rx_byte;
        POS_ID_LO: id_r[2:0]       <= rx_byte[7:5];
        POS_WA_HI: word_a_r[15:8]  <= rx_byte;
        POS_WA_LO: word_a_r[7:0]   <= rx_byte;
        POS_WB_HI: word_b_r[15:8]  <= rx_byte;
        POS_WB_LO: word_b_r[7:0]   <= rx_byte;
        POS_WC_HI: word_c_r[15:8]  <= rx_byte;
        POS_WC_LO: word_c_r[7:0]   <= rx_byte;
        POS_WD_HI: word_d_r[15:8]  <= rx_byte;
        POS_WD_LO: word_d_r[7:0]   <= rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    rec.sum    = sum_r;
    rec.chk    = rx_byte;
    rec.chan_b = chan_b_r;
    rec.msg_id = id_r;
    rec.word_a = word_a_r;
    rec.word_b = word_b_r;
    rec.word_c = word_c_r;
    rec.word_d = word_d_r;
  end

endmodule

`default_nettype wire

// ===== rtl/ffp_queue.sv =====
// short frame queue between the front end and the back end
// depends on ffp_pkg
`default_nettype none

module ffp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ffp_pkg::frame_rec_t push_rec,
  input  wire logic                pop,
  output ffp_pkg::frame_rec_t      head,
  output ffp_pkg::q_status_t       stat
);

  localparam int QD = ffp_pkg::QDEPTH;
  localparam int PW = (ffp_pkg::QPTR_W < 1) ? 1 : ffp_pkg::QPTR_W;
  localparam int CW = ffp_pkg::QCNT_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(QD - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QD);

  ffp_pkg::frame_rec_t slot_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign do_push = push && (count_r != CNT_FULL);
  assign do_pop  = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign stat.count = count_r;

endmodule

`default_nettype wire

// ===== rtl/ffp_back.sv =====
// back end: checksum fold, message classification and output register
// depends on ffp_pkg
`default_nettype none

module ffp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ffp_pkg::frame_rec_t head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_checksum_ok,
  output logic                     out_channel_b,
  output logic [10:0]              out_message_id,
  output logic [15:0]              out_word_a,
  output logic [15:0]              out_word_b,
  output logic [15:0]              out_word_c,
  output logic [15:0]              out_word_d,
  output logic [3:0]               out_msg_kind
);

  localparam logic [10:0] ID_EMPTY_A = 11'h400;
  localparam logic [10:0] ID_TILT    = 11'h401;
  localparam logic [10:0] ID_VEL     = 11'h402;
  localparam logic [10:0] ID_WHEEL   = 11'h403;
  localparam logic [10:0] ID_FWD_YAW = 11'h404;
  localparam logic [10:0] ID_TORQUE  = 11'h405;
  localparam logic [10:0] ID_STATUS  = 11'h406;
  localparam logic [10:0] ID_EMPTY_B = 11'h407;
  localparam logic [10:0] ID_HEART   = 11'h680;
  localparam logic [10:0] ID_EMPTY_C = 11'h688;

  logic                valid_r;
  logic                ok_r, chan_b_r;
  logic [10:0]         id_r;
  logic [15:0]         wa_r, wb_r, wc_r, wd_r;
  ffp_pkg::msg_kind_t  kind_r, kind_nxt, id_kind;
  logic [8:0]          fold1, fold2;
  logic [7:0]          csum;
  logic                ok_nxt;

  // fold carries above bit 7 back in twice, then negate
  assign fold1  = {1'b0, head.sum[7:0]} + {4'd0, head.sum[12:8]};
  assign fold2  = {1'b0, fold1[7:0]} + {8'd0, fold1[8]};
  assign csum   = 8'd0 - fold2[7:0];
  assign ok_nxt = (csum == head.chk);

  always_comb begin
    unique case (head.msg_id) inside
      ID_EMPTY_A, ID_EMPTY_B, ID_EMPTY_C: id_kind = ffp_pkg::KIND_EMPTY;
      ID_TILT:    id_kind = ffp_pkg::KIND_TILT;
      ID_VEL:     id_kind = ffp_pkg::KIND_VELOCITY;
      ID_WHEEL:   id_kind = ffp_pkg::KIND_WHEEL_DISPL;
      ID_FWD_YAW: id_kind = ffp_pkg::KIND_FWD_YAW_DISPL;
      ID_TORQUE:  id_kind = ffp_pkg::KIND_TORQUE;
      ID_STATUS:  id_kind = ffp_pkg::KIND_STATUS;
      ID_HEART:   id_kind = ffp_pkg::KIND_HEARTBEAT;
      default:    id_kind = ffp_pkg::KIND_UNKNOWN;
    endcase
    kind_nxt = (ok_nxt && !head.chan_b) ? id_kind : ffp_pkg::KIND_UNDECODED;
  end

  assign pop = !q_empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ok_r     <= ok_nxt;
      chan_b_r <= head.chan_b;
      id_r     <= head.msg_id;
      wa_r     <= head.word_a;
      wb_r     <= head.word_b;
      wc_r     <= head.word_c;
      wd_r     <= head.word_d;
      kind_r   <= kind_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_checksum_ok = ok_r;
  assign out_channel_b   = chan_b_r;
  assign out_message_id  = id_r;
  assign out_word_a      = wa_r;
  assign out_word_b      = wb_r;
  assign out_word_c      = wc_r;
  assign out_word_d      = wd_r;
  assign out_msg_kind    = kind_r;

endmodule

`default_nettype wire

// ===== rtl/feedback_frame_parser_unit.sv =====
// top level of the feedback frame parser: front end, frame queue, back end
// depends on ffp_pkg, ffp_front, ffp_queue, ffp_back and the assertion header
`default_nettype none

// Takes one received byte per clock while in_stall is low and hunts for
// 18-byte frames starting F0 55 AA/BB. The byte that completes a frame is
// taken in its cycle and its result passes through the frame queue and the
// output register to the out_ side. in_stall rises only when the two-entry
// frame queue between the front end and the output register is full, which
// happens only when out_stall holds results back. Message id, words and channel
// always carry the raw frame; msg_kind is zero on a bad checksum or channel BB.
module feedback_frame_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_checksum_ok,
  output logic             out_channel_b,
  output logic [10:0]      out_message_id,
  output logic [15:0]      out_word_a,
  output logic [15:0]      out_word_b,
  output logic [15:0]      out_word_c,
  output logic [15:0]      out_word_d,
  output logic [3:0]       out_msg_kind
);

`include "feedback_frame_parser_unit_assert.svh"

  logic                 take;
  logic                 push;
  logic                 pop;
  ffp_pkg::frame_rec_t  push_rec;
  ffp_pkg::frame_rec_t  head;
  ffp_pkg::q_status_t   q_stat;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !in_stall;

  ffp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (push),
    .rec     (push_rec)
  );

  ffp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ffp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_stat.empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum_ok (out_checksum_ok),
    .out_channel_b   (out_channel_b),
    .out_message_id  (out_message_id),
    .out_word_a      (out_word_a),
    .out_word_b      (out_word_b),
    .out_word_c      (out_word_c),
    .out_word_d      (out_word_d),
    .out_msg_kind    (out_msg_kind)
  );

  // a decoded kind only on a good frame from channel aa
  `FFP_ASSERT_IMPL(a_kind_needs_good,
                   out_valid && out_msg_kind != ffp_pkg::KIND_UNDECODED,
                   out_checksum_ok && !out_channel_b)
  `FFP_ASSERT_IMPL(a_kind_range, out_valid, out_msg_kind <= ffp_pkg::KIND_HEARTBEAT)
  `FFP_ASSERT_IMPL(a_no_push_full, push, !q_stat.full)
  `FFP_ASSERT_NEXT(a_push_lands, push && !pop, !q_stat.empty)

endmodule

`default_nettype wire

// ===== tb/sv/feedback_frame_parser_unit_test.sv =====
// self-checking bench for feedback_frame_parser_unit: table-driven frames, then random byte streams
// a local decoder predicts results, table rows give theirs; depends on ffp_pkg and the parser rtl
module feedback_frame_parser_unit_test;
  import ffp_pkg::*;

  localparam logic [7:0] SYNC0  = 8'hF0;
  localparam logic [7:0] SYNC1  = 8'h55;
  localparam logic [7:0] CHAN_A = 8'hAA;
  localparam logic [7:0] CHAN_B = 8'hBB;

  localparam logic [10:0] ID_EMPTY_LO  = 11'h400;
  localparam logic [10:0] ID_TILT      = 11'h401;
  localparam logic [10:0] ID_VELOCITY  = 11'h402;
  localparam logic [10:0] ID_WHEEL     = 11'h403;
  localparam logic [10:0] ID_FWD_YAW   = 11'h404;
  localparam logic [10:0] ID_TORQUE    = 11'h405;
  localparam logic [10:0] ID_STATUS    = 11'h406;
  localparam logic [10:0] ID_EMPTY_HI  = 11'h407;
  localparam logic [10:0] ID_HEARTBEAT = 11'h680;
  localparam logic [10:0] ID_EMPTY_HB  = 11'h688;

  localparam int FRAME_BYTES = 18;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        ok;
    logic        chan_b;
    logic [10:0] id;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    msg_kind_t   kind;
  } frame_report_t;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_RAW
  } row_kind_t;

  typedef struct packed {
    row_kind_t   what;
    logic [7:0]  tag;
    logic [10:0] id;
    logic [63:0] words;
    logic        bad;
    logic        typed;
    msg_kind_t   kind;
    logic [31:0] raw;
    logic [2:0]  n_raw;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_checksum_ok;
  logic        out_channel_b;
  logic [10:0] out_message_id;
  logic [15:0] out_word_a;
  logic [15:0] out_word_b;
  logic [15:0] out_word_c;
  logic [15:0] out_word_d;
  logic [3:0]  out_msg_kind;

  // decoder state
  logic [4:0]  hunt_pos = 5'd0;
  logic [7:0]  held [FRAME_BYTES];
  logic [12:0] byte_sum = 13'd0;

  frame_report_t parsed_frames_due [$];
  stim_row_t     dir_rows [$];
  logic [10:0]   known_ids [10];

  int  bytes_sent = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  stall_left = 0;

  feedback_frame_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum_ok (out_checksum_ok),
    .out_channel_b   (out_channel_b),
    .out_message_id  (out_message_id),
    .out_word_a      (out_word_a),
    .out_word_b      (out_word_b),
    .out_word_c      (out_word_c),
    .out_word_d      (out_word_d),
    .out_msg_kind    (out_msg_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sum folded twice, then two's complement
  function automatic logic [7:0] link_checksum(logic [12:0] s);
    logic [8:0] c;
    c = {1'b0, s[7:0]} + 9'(s[12:8]);
    c = {1'b0, c[7:0]} + 9'(c[8]);
    return 8'(9'd0 - c);
  endfunction

  function automatic msg_kind_t classify_id(logic [10:0] id);
    case (id)
      ID_EMPTY_LO, ID_EMPTY_HI, ID_EMPTY_HB: return KIND_EMPTY;
      ID_TILT:      return KIND_TILT;
      ID_VELOCITY:  return KIND_VELOCITY;
      ID_WHEEL:     return KIND_WHEEL_DISPL;
      ID_FWD_YAW:   return KIND_FWD_YAW_DISPL;
      ID_TORQUE:    return KIND_TORQUE;
      ID_STATUS:    return KIND_STATUS;
      ID_HEARTBEAT: return KIND_HEARTBEAT;
      default:      return KIND_UNKNOWN;
    endcase
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    frame_report_t r;
    logic [15:0]   id_word;
    case (hunt_pos)
      5'd0: begin
        if (b == SYNC0) begin
          held[0] = b;
          byte_sum = 13'(b);
          hunt_pos = 5'd1;
        end
      end
      5'd1: begin
        if (b == SYNC1) begin
          held[1] = b;
          byte_sum = byte_sum + 13'(b);
          hunt_pos = 5'd2;
        end else begin
          hunt_pos = 5'd0;
        end
      end
      5'd2: begin
        if (b == CHAN_A || b == CHAN_B) begin
          held[2] = b;
          byte_sum = byte_sum + 13'(b);
          hunt_pos = 5'd3;
        end else begin
          hunt_pos = 5'd0;
        end
      end
      default: begin
        held[hunt_pos] = b;
        if (hunt_pos < 5'(FRAME_BYTES - 1)) begin
          byte_sum = byte_sum + 13'(b);
          hunt_pos = hunt_pos + 5'd1;
        end else begin
          id_word = {held[4], held[5]};
          r.ok = (link_checksum(byte_sum) == b);
          r.chan_b = (held[2] == CHAN_B);
          r.id = id_word[15:5];
          r.word_a = {held[9], held[10]};
          r.word_b = {held[11], held[12]};
          r.word_c = {held[13], held[14]};
          r.word_d = {held[15], held[16]};
          r.kind = (r.ok && !r.chan_b) ? classify_id(r.id) : KIND_UNDECODED;
          parsed_frames_due.insert(parsed_frames_due.size(), r);
          hunt_pos = 5'd0;
          byte_sum = 13'd0;
        end
      end
    endcase
  endtask

  // returns at the edge where the request is taken
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] tag, input logic [10:0] id,
                            input logic [63:0] words, input bit bad);
    logic [7:0]  fb [FRAME_BYTES];
    logic [12:0] s;
    fb[0] = SYNC0;
    fb[1] = SYNC1;
    fb[2] = tag;
    fb[3] = 8'($urandom);
    fb[4] = id[10:3];
    fb[5] = {id[2:0], 5'($urandom)};
    fb[6] = 8'($urandom);
    fb[7] = 8'($urandom);
    fb[8] = 8'($urandom);
    for (int i = 0; i < 8; i++) fb[9 + i] = words[63 - 8 * i -: 8];
    s = 13'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) s = s + 13'(fb[i]);
    fb[17] = link_checksum(s) ^ (bad ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i]);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t frame_row(logic [7:0] tag, logic [10:0] id, logic [63:0] words,
                                          logic bad, msg_kind_t kind);
    stim_row_t r;
    r = '0;
    r.what = ROW_FRAME;
    r.tag = tag;
    r.id = id;
    r.words = words;
    r.bad = bad;
    r.typed = 1'b1;
    r.kind = kind;
    return r;
  endfunction

  function automatic stim_row_t raw_row(logic [31:0] raw, logic [2:0] n);
    stim_row_t r;
    r = '0;
    r.what = ROW_RAW;
    r.kind = KIND_UNDECODED;
    r.raw = raw;
    r.n_raw = n;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (parsed_frames_due.size() == 0) begin
        report_mismatch("result with none pending", out_message_id, 0);
      end else begin
        want = parsed_frames_due.pop_front();
        if (out_checksum_ok !== want.ok)
          report_mismatch("checksum_ok", out_checksum_ok, want.ok);
        if (out_channel_b !== want.chan_b)
          report_mismatch("channel_b", out_channel_b, want.chan_b);
        if (out_message_id !== want.id)
          report_mismatch("message_id", out_message_id, want.id);
        if (out_word_a !== want.word_a) report_mismatch("word_a", out_word_a, want.word_a);
        if (out_word_b !== want.word_b) report_mismatch("word_b", out_word_b, want.word_b);
        if (out_word_c !== want.word_c) report_mismatch("word_c", out_word_c, want.word_c);
        if (out_word_d !== want.word_d) report_mismatch("word_d", out_word_d, want.word_d);
        if (out_msg_kind !== 4'(want.kind))
          report_mismatch("msg_kind", out_msg_kind, 4'(want.kind));
      end
    end
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t     r;
    frame_report_t typed_res;
    logic [7:0]    tag;
    logic [10:0]   id;
    int            sel;

    foreach (held[i]) held[i] = 8'h00;
    known_ids = '{ID_EMPTY_LO, ID_TILT, ID_VELOCITY, ID_WHEEL, ID_FWD_YAW,
                  ID_TORQUE, ID_STATUS, ID_EMPTY_HI, ID_HEARTBEAT, ID_EMPTY_HB};

    dir_rows = '{
      frame_row(CHAN_A, ID_TILT,      64'h0,                   1'b0, KIND_TILT),
      raw_row(32'h00FF55AA, 3'd4),  // hunting drops every byte that is not the first sync byte
      frame_row(CHAN_A, ID_VELOCITY,  '1,                      1'b0, KIND_VELOCITY),
      frame_row(CHAN_A, ID_WHEEL,     64'h0001_8000_7FFF_FFFE, 1'b0, KIND_WHEEL_DISPL),
      frame_row(CHAN_A, ID_FWD_YAW,   64'h1234_5678_9ABC_DEF0, 1'b0, KIND_FWD_YAW_DISPL),
      frame_row(CHAN_A, ID_TORQUE,    64'hA5A5_5A5A_0F0F_F0F0, 1'b0, KIND_TORQUE),
      raw_row(32'hF0F055AA, 3'd4),  // bad second byte, the dropped sync is not rechecked
      frame_row(CHAN_A, ID_STATUS,    64'h00FF_FF00_8001_7FFE, 1'b0, KIND_STATUS),
      frame_row(CHAN_A, ID_HEARTBEAT, 64'hFFFF_0000_FFFF_0000, 1'b0, KIND_HEARTBEAT),
      raw_row(32'hF0555500, 3'd3),  // bad third byte
      frame_row(CHAN_A, ID_EMPTY_LO,  64'h0,                   1'b0, KIND_EMPTY),
      frame_row(CHAN_A, ID_EMPTY_HI,  '1,                      1'b0, KIND_EMPTY),
      frame_row(CHAN_A, ID_EMPTY_HB,  64'h0,                   1'b0, KIND_EMPTY),
      frame_row(CHAN_A, 11'h000,      '1,                      1'b0, KIND_UNKNOWN),
      frame_row(CHAN_A, 11'h7FF,      64'h0,                   1'b0, KIND_UNKNOWN),
      frame_row(CHAN_B, ID_TILT,      64'h0102_0304_0506_0708, 1'b0, KIND_UNDECODED),
      frame_row(CHAN_A, ID_VELOCITY,  64'h8080_8080_8080_8080, 1'b1, KIND_UNDECODED),
      frame_row(CHAN_B, 11'h7FF,      '1,                      1'b1, KIND_UNDECODED)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      if (r.what == ROW_RAW) begin
        for (int j = 0; j < int'(r.n_raw); j++) send_byte(r.raw[31 - 8 * j -: 8]);
      end else begin
        send_frame(r.tag, r.id, r.words, r.bad);
        typed_res.ok = !r.bad;
        typed_res.chan_b = (r.tag == CHAN_B);
        typed_res.id = r.id;
        typed_res.word_a = r.words[63:48];
        typed_res.word_b = r.words[47:32];
        typed_res.word_c = r.words[31:16];
        typed_res.word_d = r.words[15:0];
        typed_res.kind = r.kind;
        parsed_frames_due[parsed_frames_due.size() - 1] = typed_res;
      end
    end

    // back-to-back requests against a long receiver hold-off fill the frame queue
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (8) begin
      send_frame(CHAN_A, known_ids[$urandom_range(0, 9)],
                 {rand_word(), rand_word(), rand_word(), rand_word()}, 1'b0);
    end
    tx_idle_on = 1'b1;

    while (bytes_sent < 450) begin
      if (bytes_sent >= 400) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        tag = ($urandom_range(0, 4) == 0) ? CHAN_B : CHAN_A;
        id = ($urandom_range(0, 1) == 0) ? known_ids[$urandom_range(0, 9)] : 11'($urandom);
        send_frame(tag, id, {rand_word(), rand_word(), rand_word(), rand_word()},
                   $urandom_range(0, 6) == 0);
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 5))
          send_byte(($urandom_range(0, 4) == 0) ? SYNC0 : 8'($urandom));
      end else if (sel < 95) begin
        send_byte(SYNC0);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'($urandom));
        end else begin
          send_byte(SYNC1);
          send_byte(8'($urandom));
        end
      end else begin
        // cut-off frame: the next header ends up inside its payload
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(CHAN_A);
        repeat ($urandom_range(1, 14)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (parsed_frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffp_pkg.sv
rtl/ffp_front.sv
rtl/ffp_queue.sv
rtl/ffp_back.sv
rtl/feedback_frame_parser_unit.sv
tb/sv/feedback_frame_parser_unit_test.sv
